// ===== design/sbs_pkg.sv =====
// Shared constants and types for the sorted-table binary search unit.
package sbs_pkg;

  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

// ===== design/sbs_table_mem.sv =====
// Table storage: one write port and one registered read port.
module sbs_table_mem #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/sbs_ctrl.sv =====
// Search sequencer: holds the bounds, issues probes and forms the result.
module sbs_ctrl
  import sbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          operation,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic [COUNT_W-1:0]            entry_count,
  output logic                          busy,
  output logic                          rd_en,
  output logic [ADDR_W-1:0]             rd_addr,
  input  logic signed [VALUE_WIDTH-1:0] rd_data,
  output logic                          done,
  output result_t                       result
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;

  logic [1:0]                    state;
  logic [CNT_W-1:0]              lo;
  logic [CNT_W-1:0]              upper;   // exclusive upper bound
  logic [ADDR_W-1:0]             mid;
  logic signed [VALUE_WIDTH-1:0] key;

  logic [CNT_W-1:0]  count_used;
  logic [CNT_W:0]    sum;
  logic [ADDR_W-1:0] mid_next;
  logic              empty;

  // Counts above the table depth search the whole table.
  assign count_used = (CMP_W'(entry_count) > CMP_W'(TABLE_DEPTH)) ?
                      CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count);

  // The midpoint of [lo, upper-1], rounded down; only used while the range is non-empty.
  assign sum      = (CNT_W+1)'(lo) + (CNT_W+1)'(upper) - (CNT_W+1)'(1);
  assign mid_next = ADDR_W'(sum >> 1);
  assign empty    = (lo >= upper);

  assign busy    = (state != ST_IDLE);
  assign rd_en   = (state == ST_PROBE) && !empty;
  assign rd_addr = mid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start && operation == OP_SEARCH) begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (empty) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (rd_data == key) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_PROBE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start && operation == OP_SEARCH) begin
          lo    <= '0;
          upper <= count_used;
          key   <= value;
        end
      end
      ST_PROBE: begin
        mid <= mid_next;
        if (empty) begin
          result.found    <= 1'b0;
          result.position <= '0;
        end
      end
      ST_CMP: begin
        if (rd_data == key) begin
          result.found    <= 1'b1;
          result.position <= POS_W'(mid);
        end else if (rd_data > key) begin
          upper <= CNT_W'(mid);
        end else begin
          lo <= CNT_W'(mid) + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_search_enters_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && operation == OP_SEARCH |=> busy)
    else $error("search request did not start the sequencer");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a running search");

  a_miss_position_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.position == '0)
    else $error("not-found result carries a nonzero position");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> (CNT_W'(mid) >= lo) && (CNT_W'(mid) < upper))
    else $error("probe position outside the search range");
`endif

endmodule

// ===== design/sorted_table_binary_search_unit.sv =====
// Top level of the sorted-table binary search unit.
//
// A request is taken at a rising edge where start is high and busy is low.
// A write request (operation low) stores value at entry_index
// and gives no result; busy stays low, so writes can follow every cycle.
// An index beyond the table depth is dropped. A search request (operation
// high) looks for value among entries 0 to entry_count-1, which the user
// keeps sorted ascending. Each probe takes the PROBE state, which issues the
// registered memory read of the midpoint, and the CMP state for the compare
// and bound update. A search that hits strobes its result from the compare of
// its last probe. A search that misses after p probes goes through the PROBE
// state once more to see the empty range before it strobes. The worst case
// for a 1024-entry table is 11 probes, then the miss. The result sits
// on found and position for exactly one cycle marked by done; it cannot be held
// off, and busy is already low in that cycle so the next request may enter.
// entry_count is written through the cfg channel, which is always ready and
// must only be used while the unit is idle. Reset clears entry_count and the
// sequencer; table contents are undefined until written.
module sorted_table_binary_search_unit
  import sbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [INDEX_W-1:0]            entry_index,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [COUNT_W-1:0]            cfg_data,
  output logic                          done,
  output logic                          found,
  output logic [POS_W-1:0]              position
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [COUNT_W-1:0]            entry_count;
  logic                          accept;
  logic                          wr_en;
  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_addr;
  logic signed [VALUE_WIDTH-1:0] rd_data;
  result_t                       result;

  // The count register can take a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  assign accept = start && !busy;

  // Writes go straight into the table at the request edge. Searches read only
  // while busy, so a write and a probe never touch the memory together.
  assign wr_en = accept && (operation == OP_WRITE) &&
                 (32'(entry_index) < 32'(TABLE_DEPTH));

  sbs_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(entry_index)),
    .wr_data (value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .operation   (operation),
    .value       (value),
    .entry_count (entry_count),
    .busy        (busy),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .done        (done),
    .result      (result)
  );

  assign found    = result.found;
  assign position = result.position;

endmodule
